@@ rtl/tab_pkg.sv @@
package tab_pkg;

	localparam int MaxWidth  = 64;
	localparam int MaxHeight = 64;
	localparam int MaxPasses = 256;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MODE   = 2'd2;
	localparam logic [1:0] REG_PASSES = 2'd3;

	localparam logic [23:0] FLAT_NORMAL = 24'hFF7F7F;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [8:0] passes;
		logic       err;
	} result_t;

endpackage

@@ rtl/tab_frame_mem.sv @@
module tab_frame_mem #(
	parameter int Depth = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/texture_alpha_bleed.sv @@
// Pixel write: result registered on the accepting edge; new requests stall while it is
// held. Pixel read: the word passes the memory read register, then the result register;
// new requests stall until that result is taken. Run: prep sweep reads each pixel and
// writes each transparent one (flat normal in mode 1, ending the run; else zero color),
// then each pass probes up to eight neighbors of a transparent black pixel in turn (one
// memory port). Reset clears control state and result; config takes its defaults.
module texture_alpha_bleed #(
	parameter int MAX_WIDTH  = tab_pkg::MaxWidth,
	parameter int MAX_HEIGHT = tab_pkg::MaxHeight,
	parameter int MAX_PASSES = tab_pkg::MaxPasses
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [11:0] pixel_index,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	input  logic [7:0]  in_alpha,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha,
	output logic [8:0]  passes_run,
	output logic        index_error
);

	localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int XW = $clog2(MAX_WIDTH + 1);
	localparam int YW = $clog2(MAX_HEIGHT + 1);
	localparam int PW = $clog2(MAX_PASSES + 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_READ  = 9'b000000010,
		S_PREP  = 9'b000000100,
		S_PREPW = 9'b000001000,
		S_CTR   = 9'b000010000,
		S_CTRW  = 9'b000100000,
		S_NB    = 9'b001000000,
		S_NBW   = 9'b010000000,
		S_PEND  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [6:0] width_q, height_q;
	logic       mode_q;
	logic [8:0] limit_q;

	logic [XW-1:0] w_eff, x_q;
	logic [YW-1:0] h_eff, y_q;
	logic [PW-1:0] lim_eff, passes_q;
	logic [AW-1:0] idx_q;
	logic [AW+1:0] count;
	logic [2:0]    k_q;
	logic          changed_q, nb_ok;
	logic [31:0]   ctr_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata;

	tab_pkg::result_t res_q;
	logic             res_valid_q;

	always_comb begin
		if (width_q == 7'd0) w_eff = XW'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
		else w_eff = XW'(width_q);
		if (height_q == 7'd0) h_eff = YW'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
		else h_eff = YW'(height_q);
		if (limit_q == 9'd0) lim_eff = PW'(1);
		else if (32'(limit_q) > MAX_PASSES) lim_eff = PW'(MAX_PASSES);
		else lim_eff = PW'(limit_q);
	end

	// frame size, registered product of the effective width and height
	logic [AW:0] n_q;
	always_ff @(posedge clk) begin
		n_q <= (AW+1)'(w_eff * h_eff);
	end
	assign count = (AW+2)'(n_q);

	// neighbor offsets in the order right, down, down-right, down-left, left,
	// up, up-left, up-right
	logic signed [1:0] dx, dy;
	always_comb begin
		case (k_q)
			3'd0: begin dx = 2'sd1;  dy = 2'sd0;  end
			3'd1: begin dx = 2'sd0;  dy = 2'sd1;  end
			3'd2: begin dx = 2'sd1;  dy = 2'sd1;  end
			3'd3: begin dx = -2'sd1; dy = 2'sd1;  end
			3'd4: begin dx = -2'sd1; dy = 2'sd0;  end
			3'd5: begin dx = 2'sd0;  dy = -2'sd1; end
			3'd6: begin dx = -2'sd1; dy = -2'sd1; end
			default: begin dx = 2'sd1; dy = -2'sd1; end
		endcase
	end

	logic signed [XW+1:0] nx;
	logic signed [YW+1:0] ny;
	logic [AW-1:0]        nb_addr;
	always_comb begin
		nx = $signed({2'b00, x_q}) + (XW+2)'(dx);
		ny = $signed({2'b00, y_q}) + (YW+2)'(dy);
		nb_ok = (nx >= 0) && (ny >= 0) && (nx < $signed({2'b00, w_eff}))
			&& (ny < $signed({2'b00, h_eff}));
		nb_addr = AW'(32'(idx_q) + 32'(dx) + 32'(dy) * 32'(w_eff));
	end

	logic in_acc, last_pix;
	assign in_stall = (state_q != S_IDLE) || res_valid_q;
	assign in_acc   = in_valid && !in_stall;
	assign last_pix = (32'(idx_q) + 1) >= 32'(count);

	logic in_range;
	assign in_range = (32'(pixel_index) < 32'(count));

	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wdata = 32'd0;
		raddr = idx_q;
		if (state_q == S_IDLE) begin
			raddr = AW'(pixel_index);
			waddr = AW'(pixel_index);
			wdata = {in_alpha, in_blue, in_green, in_red};
			we = in_acc && opcode == tab_pkg::OP_WRITE && in_range;
		end else if (state_q == S_PREPW) begin
			we = rdata[31:24] == 8'd0;
			wdata = {8'd0, mode_q ? tab_pkg::FLAT_NORMAL : 24'd0};
		end else if (state_q == S_NB) begin
			raddr = nb_addr;
		end else if (state_q == S_NBW) begin
			we = nb_ok && rdata[23:0] != 24'd0;
			wdata = {ctr_q[31:24], rdata[23:0]};
		end
	end

	tab_frame_mem #(.Depth(Depth), .AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			width_q <= 7'd16;
			height_q <= 7'd16;
			mode_q <= 1'b0;
			limit_q <= 9'd256;
			res_valid_q <= 1'b0;
			res_q <= '0;
			idx_q <= '0;
			x_q <= '0;
			y_q <= '0;
			k_q <= '0;
			passes_q <= '0;
			changed_q <= 1'b0;
			ctr_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tab_pkg::REG_WIDTH:  width_q <= cfg_data[6:0];
					tab_pkg::REG_HEIGHT: height_q <= cfg_data[6:0];
					tab_pkg::REG_MODE:   mode_q <= cfg_data[0];
					tab_pkg::REG_PASSES: limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (res_valid_q && !out_stall) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (opcode == tab_pkg::OP_WRITE || opcode == tab_pkg::OP_READ) begin
							if (!in_range) begin
								res_q <= '{err: 1'b1, default: '0};
								res_valid_q <= 1'b1;
							end else if (opcode == tab_pkg::OP_READ) begin
								res_q <= '0;
								state_q <= S_READ;
							end else begin
								res_q <= '0;
								res_valid_q <= 1'b1;
							end
						end else if (opcode == tab_pkg::OP_RUN) begin
							res_q <= '0;
							idx_q <= '0;
							state_q <= S_PREP;
						end else begin
							res_q <= '0;
							res_valid_q <= 1'b1;
						end
					end
				end
				S_READ: begin
					{res_q.alpha, res_q.blue, res_q.green, res_q.red} <= rdata;
					res_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_PREP: state_q <= S_PREPW;
				S_PREPW: begin
					if (!last_pix) begin
						idx_q <= idx_q + AW'(1);
						state_q <= S_PREP;
					end else if (mode_q) begin
						changed_q <= 1'b0;
						res_q.passes <= 9'd0;
						res_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= '0;
						x_q <= '0;
						y_q <= '0;
						passes_q <= '0;
						changed_q <= 1'b0;
						state_q <= S_CTR;
					end
				end
				S_CTR: state_q <= S_CTRW;
				S_CTRW: begin
					ctr_q <= rdata;
					k_q <= '0;
					if (rdata == 32'd0) state_q <= S_NB;
					else state_q <= S_PEND;
				end
				S_NB: state_q <= S_NBW;
				S_NBW: begin
					if (nb_ok && rdata[23:0] != 24'd0) begin
						changed_q <= 1'b1;
						state_q <= S_PEND;
					end else if (k_q == 3'd7) begin
						state_q <= S_PEND;
					end else begin
						k_q <= k_q + 3'd1;
						state_q <= S_NB;
					end
				end
				S_PEND: begin
					if (!last_pix) begin
						idx_q <= idx_q + AW'(1);
						if (x_q == w_eff - XW'(1)) begin
							x_q <= '0;
							y_q <= y_q + YW'(1);
						end else begin
							x_q <= x_q + XW'(1);
						end
						state_q <= S_CTR;
					end else if (changed_q && (passes_q + PW'(1)) < lim_eff) begin
						// start another pass
						passes_q <= passes_q + PW'(1);
						changed_q <= 1'b0;
						idx_q <= '0;
						x_q <= '0;
						y_q <= '0;
						state_q <= S_CTR;
					end else begin
						res_q.passes <= 9'(passes_q + PW'(1));
						res_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = res_valid_q;
	assign out_red     = res_q.red;
	assign out_green   = res_q.green;
	assign out_blue    = res_q.blue;
	assign out_alpha   = res_q.alpha;
	assign passes_run  = res_q.passes;
	assign index_error = res_q.err;

endmodule
